// ----- rtl/core/srde_pkg.sv -----
package srde_pkg;

   localparam int MAX_BASE_DEF   = 16;
   localparam int VALUE_BITS_DEF = 32;

   localparam int CHAR_W      = 8;
   localparam int BASE_W      = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 2;
   localparam int ALPHA_CHARS = 16;
   localparam int ALPHA_IDX_W = 4;

   // quotient bits retired per divider cycle
   localparam int DIV_STEP_BITS = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_LO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_HI  = 2'd2;

   localparam logic [BASE_W-1:0]     BASE_SIZE_RST = 5'd10;
   localparam logic [CSR_DATA_W-1:0] ALPHA_LO_RST  = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] ALPHA_HI_RST  = 64'h6665646362613938;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

   function automatic logic [CHAR_W-1:0] alpha_char(
      input logic [CSR_DATA_W-1:0]  lo,
      input logic [CSR_DATA_W-1:0]  hi,
      input logic [ALPHA_IDX_W-1:0] idx
   );
      logic [2*CSR_DATA_W-1:0] packed_chars;
      packed_chars = {hi, lo};
      return packed_chars[idx*CHAR_W +: CHAR_W];
   endfunction

endpackage

// ----- rtl/core/srde_if.sv -----
interface srde_req_if
   import srde_pkg::*;
#(
   parameter int VB = VALUE_BITS_DEF
)();
   logic                 valid;
   logic                 ready;
   logic signed [VB-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface srde_rsp_if
   import srde_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_out;
   logic              last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

interface srde_csr_if
   import srde_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/srde_ram.sv -----
module srde_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
)(
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/srde_div.sv -----
module srde_div
   import srde_pkg::*;
#(
   parameter int QW = 32,
   parameter int DW = 4
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QW-1:0]     dividend,
   input  logic [BASE_W-1:0] divisor,
   output logic              done,
   output logic [QW-1:0]     quotient,
   output logic [DW-1:0]     remainder
);
   localparam int CYC   = QW / DIV_STEP_BITS;
   localparam int CNT_W = (CYC > 1) ? $clog2(CYC) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    rem_ff, rem_in;

   logic [DW:0]      dv;
   logic [DW:0]      step_t;
   logic [QW-1:0]    step_q;
   logic [DW-1:0]    step_r;

   // divisor is a checked radix, so it fits DW+1 bits
   assign dv = (DW+1)'(divisor);

   // restoring division, DIV_STEP_BITS shift/compare/subtract steps per cycle
   always_comb begin
      step_q = quo_ff;
      step_r = rem_ff;
      step_t = '0;
      for (int s = 0; s < DIV_STEP_BITS; s++) begin
         step_t = {step_r, step_q[QW-1]};
         step_q = {step_q[QW-2:0], 1'b0};
         if (step_t >= dv) begin
            step_t    = step_t - dv;
            step_q[0] = 1'b1;
         end
         step_r = step_t[DW-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = step_q;
         rem_in = step_r;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CYC - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/core/srde_alpha_chk.sv -----
module srde_alpha_chk
   import srde_pkg::*;
#(
   parameter int MAX_BASE = MAX_BASE_DEF
)(
   input  logic                  clock,
   input  logic [BASE_W-1:0]     base_size,
   input  logic [CSR_DATA_W-1:0] alpha_lo,
   input  logic [CSR_DATA_W-1:0] alpha_hi,
   output logic                  ok
);
   logic ok_ff, ok_in;
   logic [CHAR_W-1:0] ci;

   // all pairs compared at once; the flag is registered and follows the registers on the next cycle
   always_comb begin
      ok_in = (base_size >= BASE_W'(2)) && (base_size <= BASE_W'(MAX_BASE));
      ci    = '0;
      for (int i = 0; i < MAX_BASE; i++) begin
         ci = alpha_char(alpha_lo, alpha_hi, ALPHA_IDX_W'(i));
         if (BASE_W'(i) < base_size) begin
            if (ci == CH_NUL || ci == CH_PLUS || ci == CH_MINUS) begin
               ok_in = 1'b0;
            end
            for (int j = i + 1; j < MAX_BASE; j++) begin
               if (BASE_W'(j) < base_size &&
                   alpha_char(alpha_lo, alpha_hi, ALPHA_IDX_W'(j)) == ci) begin
                  ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ok_ff <= ok_in;
   end

   assign ok = ok_ff;
endmodule

// ----- rtl/core/signed_radix_digit_emitter_unit.sv -----
// Sequence: the word is registered and its alphabet checked (a bad one drops it), then
// each digit comes from the shared 8-bit-per-cycle divider (QW = VALUE_BITS rounded
// up to 8), then each character passes the digit RAM read, after a leading '-'.
// One word at a time: a new word is accepted only in the idle state.
// Reset (synchronous): sequencer idle, counts cleared, base 10, "0123456789abcdef".
// Digit RAM contents are not cleared.
module signed_radix_digit_emitter_unit
   import srde_pkg::*;
#(
   parameter int MAX_BASE   = MAX_BASE_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
)(
   input  logic       clock,
   input  logic       reset,
   srde_req_if.sink   req_ch,
   srde_rsp_if.source rsp_ch,
   srde_csr_if.sink   csr_ch
);
   localparam int DW = $clog2(MAX_BASE);
   localparam int QW = ((VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
   localparam int AW = $clog2(VALUE_BITS);
   localparam int CW = $clog2(VALUE_BITS + 1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_SIGN  = 6'b001000,
      ST_RD    = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic                  neg_ff, neg_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [QW-1:0]         work_quo_ff, work_quo_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [BASE_W-1:0]     base_ff;
   logic [CSR_DATA_W-1:0] alpha_lo_ff;
   logic [CSR_DATA_W-1:0] alpha_hi_ff;

   logic                  alpha_ok;
   logic                  div_start, div_done;
   logic [QW-1:0]         div_quo;
   logic [DW-1:0]         div_rem;
   logic                  ram_we;
   logic [DW-1:0]         ram_rdata;
   logic [CW-1:0]         cnt_inc, cnt_dec;
   logic [VALUE_BITS-1:0] mag;
   logic                  out_free;

   // ---- configuration registers ----
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_SIZE_RST;
         alpha_lo_ff <= ALPHA_LO_RST;
         alpha_hi_ff <= ALPHA_HI_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_BASE_SIZE: base_ff     <= csr_ch.data[BASE_W-1:0];
            CSR_ALPHA_LO:  alpha_lo_ff <= csr_ch.data;
            CSR_ALPHA_HI:  alpha_hi_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   srde_alpha_chk #(.MAX_BASE(MAX_BASE)) u_chk (
      .clock     (clock),
      .base_size (base_ff),
      .alpha_lo  (alpha_lo_ff),
      .alpha_hi  (alpha_hi_ff),
      .ok        (alpha_ok)
   );

   srde_div #(.QW(QW), .DW(DW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (work_quo_in),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   srde_ram #(.WIDTH(DW), .DEPTH(VALUE_BITS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (cnt_ff[AW-1:0]),
      .wdata (div_rem),
      .raddr (cnt_dec[AW-1:0]),
      .rdata (ram_rdata)
   );

   // ---- sequencer ----
   assign cnt_inc  = cnt_ff + CW'(1);
   assign cnt_dec  = cnt_ff - CW'(1);
   // minimum value negates to itself, which is its unsigned magnitude
   assign mag      = val_ff[VALUE_BITS-1] ? (~val_ff + VALUE_BITS'(1)) : val_ff;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      work_quo_in  = work_quo_ff;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               val_in   = req_ch.value;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (!alpha_ok) begin
               state_in = ST_IDLE;
            end else begin
               neg_in      = val_ff[VALUE_BITS-1];
               work_quo_in = QW'(mag);
               cnt_in      = '0;
               div_start   = 1'b1;
               state_in    = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ram_we      = 1'b1;
               cnt_in      = cnt_inc;
               work_quo_in = div_quo;
               if (div_quo != '0 && cnt_inc < CW'(VALUE_BITS)) begin
                  div_start = 1'b1;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_RD;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = alpha_char(alpha_lo_ff, alpha_hi_ff, ALPHA_IDX_W'(ram_rdata));
               rsp_last_in  = (cnt_ff == CW'(1));
               cnt_in       = cnt_dec;
               state_in     = (cnt_ff == CW'(1)) ? ST_IDLE : ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         work_quo_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         neg_ff       <= neg_in;
         cnt_ff       <= cnt_in;
         work_quo_ff  <= work_quo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      val_ff      <= val_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.char_out = rsp_char_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // ---- checks ----
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> state_ff == ST_START)
      else $error("accepted word did not start conversion");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide phase");

   a_ram_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> cnt_ff < CW'(VALUE_BITS))
      else $error("digit write beyond store depth");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(VALUE_BITS))
      else $error("digit count overflow");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && out_free && cnt_ff == CW'(1)
      |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
      else $error("final digit not marked last");
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import srde_pkg::*;

   localparam int          SETTLE_CYCLES = 300;
   localparam longint      WATCHDOG_NS   = 64'd20_000_000;
   localparam int          DIR_ROWS      = 25;
   localparam int          SEG_WORDS     = 28;
   localparam int          BAD_WORDS     = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } char_word_type;

   typedef struct {
      bit                cfg;
      logic [BASE_W-1:0] base;
      logic [63:0]       lo;
      logic [63:0]       hi;
      logic signed [31:0] value;
      bit                given;
      string             text;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   srde_req_if req_if ();
   srde_rsp_if rsp_if ();
   srde_csr_if csr_if ();

   signed_radix_digit_emitter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #5 clock = ~clock;

   // shadow of the block's registers
   logic [BASE_W-1:0] radix_shadow;
   logic [CHAR_W-1:0] alpha_shadow [ALPHA_CHARS];

   char_word_type char_expect_q [$];
   int unsigned   fail_count;
   int unsigned   send_idle_pct;
   int unsigned   recv_stall_pct;

   dir_row_type dir_table [DIR_ROWS] = '{
      // reset alphabet, base 10
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sd0,          1'b1, "0"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sh7FFF_FFFF,  1'b1, "2147483647"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sh8000_0000,  1'b1, "-2147483648"},
      '{1'b0, 5'd0,  64'h0, 64'h0, -32'sd1,         1'b1, "-1"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sd1,          1'b1, "1"},
      '{1'b0, 5'd0,  64'h0, 64'h0, -32'sd123456789, 1'b1, "-123456789"},
      // hex
      '{1'b1, 5'd16, ALPHA_LO_RST, ALPHA_HI_RST, 32'sh8000_0000, 1'b1, "-80000000"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sh7FFF_FFFF,  1'b1, "7fffffff"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sd255,        1'b1, "ff"},
      // binary: the longest runs
      '{1'b1, 5'd2,  ALPHA_LO_RST, ALPHA_HI_RST, 32'sh8000_0000, 1'b0, ""},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sh7FFF_FFFF,  1'b0, ""},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sd5,          1'b1, "101"},
      // bad alphabets emit nothing
      '{1'b1, 5'd1,  ALPHA_LO_RST, ALPHA_HI_RST, 32'sd7,  1'b1, ""},
      '{1'b1, 5'd0,  ALPHA_LO_RST, ALPHA_HI_RST, -32'sd7, 1'b1, ""},
      '{1'b1, 5'd17, ALPHA_LO_RST, ALPHA_HI_RST, 32'sd3,  1'b1, ""},
      '{1'b1, 5'd31, ALPHA_LO_RST, ALPHA_HI_RST, 32'sd3,  1'b1, ""},
      '{1'b1, 5'd10, ALPHA_LO_RST, 64'h6665_6463_6261_2D38, 32'sd42, 1'b1, ""},
      '{1'b1, 5'd10, 64'h3736_3534_3332_312B, ALPHA_HI_RST, 32'sd42, 1'b1, ""},
      '{1'b1, 5'd10, 64'h3736_3500_3332_3130, ALPHA_HI_RST, 32'sd42, 1'b1, ""},
      '{1'b1, 5'd10, 64'h3736_3534_3332_3030, ALPHA_HI_RST, 32'sd42, 1'b1, ""},
      '{1'b1, 5'd16, 64'hFFFF_FFFF_FFFF_FFFF, ALPHA_HI_RST, 32'sd42, 1'b1, ""},
      // base 3 "xyz": duplicate and nul bytes past the radix are don't-care
      '{1'b1, 5'd3,  64'h0000_0000_787A_7978, 64'h0, -32'sd8, 1'b1, "-zz"},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sd0,          1'b1, "x"},
      // high-bit characters
      '{1'b1, 5'd16, 64'h8081_FEFF_7F41_2C2A, 64'h0102_0304_F0E0_D0C0, -32'sd1, 1'b0, ""},
      '{1'b0, 5'd0,  64'h0, 64'h0, 32'sh7654_3210,  1'b0, ""}
   };

   // Characters the block should emit for v under the shadow configuration.
   function automatic void predict_chars(input logic signed [31:0] v);
      logic [31:0]       mag;
      logic [3:0]        digs [32];
      logic [CHAR_W-1:0] c;
      int unsigned       nb;
      int unsigned       n;
      bit                ok;
      nb = radix_shadow;
      ok = (nb >= 2) && (nb <= MAX_BASE_DEF);
      for (int i = 0; ok && i < nb; i++) begin
         c = alpha_shadow[i];
         if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS)
            ok = 1'b0;
         for (int j = 0; j < i; j++)
            if (alpha_shadow[j] == c)
               ok = 1'b0;
      end
      if (!ok)
         return;
      mag = v[31] ? (~v + 32'd1) : v;
      n = 0;
      do begin
         digs[n] = 4'(mag % nb);
         mag     = mag / nb;
         n++;
      end while (mag != 0);
      if (v[31])
         char_expect_q.push_back('{CH_MINUS, 1'b0});
      for (int k = n - 1; k >= 0; k--)
         char_expect_q.push_back('{alpha_shadow[digs[k]], k == 0});
   endfunction

   function automatic void log_mismatch(input string what, input char_word_type want,
                                        input char_word_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch (%s): expected char %h last %b, got char %h last %b",
                  what, want.ch, want.last, got.ch, got.last);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_digit_char();
      logic [CHAR_W-1:0] c;
      do
         c = CHAR_W'($urandom_range(1, 255));
      while (c == CH_PLUS || c == CH_MINUS);
      return c;
   endfunction

   // Distinct legal characters for the first nb slots, junk beyond.
   task automatic random_alphabet(input int unsigned nb, output logic [63:0] lo,
                                  output logic [63:0] hi);
      logic [CHAR_W-1:0] chars [ALPHA_CHARS];
      bit                dup;
      for (int i = 0; i < ALPHA_CHARS; i++) begin
         if (i < nb) begin
            do begin
               chars[i] = pick_digit_char();
               dup = 1'b0;
               for (int j = 0; j < i; j++)
                  if (chars[j] == chars[i])
                     dup = 1'b1;
            end while (dup);
         end else begin
            chars[i] = $urandom_range(1) ? CHAR_W'($urandom) : chars[$urandom_range(0, i - 1)];
         end
      end
      for (int i = 0; i < 8; i++) begin
         lo[i*8 +: 8] = chars[i];
         hi[i*8 +: 8] = chars[i+8];
      end
   endtask

   task automatic bad_alphabet(output logic [BASE_W-1:0] base, output logic [63:0] lo,
                               output logic [63:0] hi);
      logic [127:0] pk;
      int unsigned  nb;
      int unsigned  i;
      int unsigned  j;
      nb = $urandom_range(2, 16);
      random_alphabet(nb, lo, hi);
      pk = {hi, lo};
      case ($urandom_range(0, 3))
         0: nb = $urandom_range(0, 1);
         1: nb = $urandom_range(17, 31);
         2: begin
            i = $urandom_range(0, nb - 1);
            case ($urandom_range(0, 2))
               0:       pk[i*8 +: 8] = CH_NUL;
               1:       pk[i*8 +: 8] = CH_PLUS;
               default: pk[i*8 +: 8] = CH_MINUS;
            endcase
         end
         default: begin
            i = $urandom_range(1, nb - 1);
            j = $urandom_range(0, i - 1);
            pk[i*8 +: 8] = pk[j*8 +: 8];
         end
      endcase
      base = BASE_W'(nb);
      {hi, lo} = pk;
   endtask

   function automatic logic signed [31:0] random_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6: begin
            v = $urandom_range(0, 400);
            if ($urandom_range(1))
               v = -v;
         end
         7, 8: v = $signed($urandom) >>> $urandom_range(1, 31);
         default: begin
            case ($urandom_range(0, 5))
               0:       v = 32'sh8000_0000;
               1:       v = 32'sh7FFF_FFFF;
               2:       v = 32'sh8000_0001;
               3:       v = 32'sd0;
               4:       v = 32'sd1;
               default: v = -32'sd1;
            endcase
         end
      endcase
      return v;
   endfunction

   // Leaves csr valid high; the caller drops it after the last write.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready)
         @(posedge clock);
      case (idx)
         CSR_BASE_SIZE: radix_shadow = data[BASE_W-1:0];
         CSR_ALPHA_LO:  for (int i = 0; i < 8; i++) alpha_shadow[i]   = data[i*8 +: 8];
         CSR_ALPHA_HI:  for (int i = 0; i < 8; i++) alpha_shadow[i+8] = data[i*8 +: 8];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [BASE_W-1:0] base, input logic [63:0] lo,
                               input logic [63:0] hi);
      logic [63:0] d;
      d = {$urandom, $urandom};
      d[BASE_W-1:0] = base;
      write_csr(CSR_BASE_SIZE, d);
      write_csr(CSR_ALPHA_LO, lo);
      write_csr(CSR_ALPHA_HI, hi);
      // unmapped index must be ignored
      write_csr(CSR_IDX_SPARE, {$urandom, $urandom});
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (char_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // valid stays high after acceptance so back-to-back words see one assignment
   task automatic send_value(input logic signed [31:0] v, input bit given, input string text);
      int unsigned gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      if (given) begin
         for (int i = 0; i < text.len(); i++)
            char_expect_q.push_back('{text[i], i == text.len() - 1});
      end else begin
         predict_chars(v);
      end
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      char_word_type want;
      char_word_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.char_out, rsp_if.last};
         if (char_expect_q.size() == 0) begin
            log_mismatch("unexpected word", '0, got);
         end else begin
            want = char_expect_q.pop_front();
            if (want.ch !== got.ch || want.last !== got.last)
               log_mismatch("wrong word", want, got);
         end
      end
   end

   initial begin
      #(WATCHDOG_NS);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [BASE_W-1:0] base;
      logic [63:0]       lo;
      logic [63:0]       hi;
      int unsigned       phase;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.value   = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_BASE_SIZE;
      csr_if.data    = '0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      radix_shadow   = BASE_SIZE_RST;
      for (int i = 0; i < 8; i++) begin
         alpha_shadow[i]   = ALPHA_LO_RST[i*8 +: 8];
         alpha_shadow[i+8] = ALPHA_HI_RST[i*8 +: 8];
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[r]) begin
         if (dir_table[r].cfg) begin
            wait_idle();
            apply_config(dir_table[r].base, dir_table[r].lo, dir_table[r].hi);
         end
         send_value(dir_table[r].value, dir_table[r].given, dir_table[r].text);
      end

      for (int seg = 0; seg < 8; seg++) begin
         phase = seg % 4;
         send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 12 : 0;
         recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 12 : 0;
         if (seg == 3 || seg == 6) begin
            wait_idle();
            bad_alphabet(base, lo, hi);
            apply_config(base, lo, hi);
            repeat (BAD_WORDS) send_value(random_value(), 1'b0, "");
         end
         base = (seg == 0) ? 5'd2 : (seg == 1) ? 5'd16 : BASE_W'($urandom_range(2, 16));
         random_alphabet(base, lo, hi);
         wait_idle();
         apply_config(base, lo, hi);
         repeat (SEG_WORDS) send_value(random_value(), 1'b0, "");
      end

      wait_idle();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
